// ----- rtl/core/spfa_pkg.sv -----
// Shared constants and widths for the SPFA shortest path block.
package spfa_pkg;
   localparam int MAX_NODES   = 64;
   localparam int MAX_EDGES   = 256;
   localparam int WEIGHT_BITS = 16;
   localparam int NODE_W      = $clog2(MAX_NODES);
   localparam int CNT_W       = $clog2(MAX_NODES) + 1;
   localparam int EIDX_W      = $clog2(MAX_EDGES);
   localparam int LINK_W      = EIDX_W + 1;
   localparam int DIST_W      = 32;
   localparam int CFG_W       = 7;
   localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(MAX_EDGES);
   localparam logic signed [DIST_W-1:0] INF_DIST = 32'sd999999999;
   localparam logic [0:0] REG_NODE_COUNT  = 1'd0;
   localparam logic [0:0] REG_SOURCE_NODE = 1'd1;
endpackage

// ----- rtl/core/spfa_if.sv -----
// Handshake interfaces for the edge input and distance output channels.
interface spfa_req_if import spfa_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic [NODE_W-1:0]             edge_from;
   logic [NODE_W-1:0]             edge_to;
   logic signed [WEIGHT_BITS-1:0] edge_weight;
   logic                          last_edge;
   modport source (output valid, edge_from, edge_to, edge_weight, last_edge, input ready);
   modport sink (input valid, edge_from, edge_to, edge_weight, last_edge, output ready);
endinterface

interface spfa_rsp_if import spfa_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [NODE_W-1:0]        node_index;
   logic signed [DIST_W-1:0] distance;
   logic                     reachable;
   logic                     negative_cycle;
   logic                     edge_overflow;
   logic                     last_result;
   modport source (output valid, node_index, distance, reachable, negative_cycle,
                   edge_overflow, last_result, input ready);
   modport sink (input valid, node_index, distance, reachable, negative_cycle,
                 edge_overflow, last_result, output ready);
endinterface

// ----- rtl/core/spfa_relax.sv -----
// Saturating candidate distance and improvement test for one edge.
module spfa_relax import spfa_pkg::*; (
   input  logic signed [DIST_W-1:0]      du,
   input  logic signed [WEIGHT_BITS-1:0] weight,
   input  logic signed [DIST_W-1:0]      dist_v,
   input  logic                          reached_v,
   output logic signed [DIST_W-1:0]      cand,
   output logic                          improve
);
   logic signed [DIST_W:0] sum;

   always_comb begin
      sum = $signed({du[DIST_W-1], du}) + (DIST_W+1)'(weight);
      if (sum[DIST_W] != sum[DIST_W-1]) begin
         cand = sum[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
      end else begin
         cand = sum[DIST_W-1:0];
      end
      improve = !reached_v || (cand < dist_v);
   end
endmodule

// ----- rtl/core/spfa_shortest_path.sv -----
// SPFA shortest path top level: edge loading, queue-driven relaxation, result output.
// Edges load one word per cycle; the adjacency head memory is read at accept and
// written from a register with forwarding, so back-to-back edges chain correctly. After
// the word marked last_edge the block stops taking edges, relaxes from a circular node
// queue, and returns one result word per node in order, node_count clamped to 1..64.
// A dequeued node steps through ST_POP, ST_POP_W and ST_HEAD_W, a walked edge through
// ST_EDGE_W and ST_RELAX, each waiting on a registered memory read; output uses
// ST_OUT_RD and ST_OUT_LD per node. Loading resumes once the last result is registered.
module spfa_shortest_path import spfa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [0:0]          csr_index,
   input  logic [CFG_W-1:0]    csr_write_data,
   spfa_req_if.sink            req_bus,
   spfa_rsp_if.source          rsp_bus
);
   typedef enum logic [3:0] {
      ST_LOAD, ST_DRAIN, ST_INIT, ST_POP, ST_POP_W, ST_HEAD_W,
      ST_EDGE_W, ST_RELAX, ST_OUT_RD, ST_OUT_LD
   } state_type;

   state_type state_ff;

   logic [CFG_W-1:0]  node_count_ff;
   logic [NODE_W-1:0] source_ff;
   logic [CFG_W-1:0]  n_eff;

   logic [EIDX_W:0]   edges_loaded_ff;
   logic              overflow_ff;
   logic              st_vld_ff;
   logic [NODE_W-1:0] st_from_ff;
   logic [EIDX_W-1:0] st_e_ff;
   logic              fwd_vld_ff;
   logic [NODE_W-1:0] fwd_from_ff;
   logic [EIDX_W-1:0] fwd_e_ff;
   logic [MAX_NODES-1:0] head_vld_ff;

   logic [MAX_NODES-1:0] reached_ff;
   logic [MAX_NODES-1:0] queued_ff;
   logic [MAX_NODES-1:0] cnt_vld_ff;
   logic [NODE_W-1:0] q_head_ff;
   logic [NODE_W-1:0] q_tail_ff;
   logic [CNT_W-1:0]  q_len_ff;
   logic [NODE_W-1:0] u_ff;
   logic signed [DIST_W-1:0] du_ff;
   logic              neg_ff;
   logic [NODE_W-1:0] k_ff;

   logic [EIDX_W-1:0]      head_mem [MAX_NODES];
   logic [EIDX_W-1:0]      head_rdata_ff;
   logic [NODE_W-1:0]      edst_mem [MAX_EDGES];
   logic signed [WEIGHT_BITS-1:0] ewt_mem [MAX_EDGES];
   logic [LINK_W-1:0]      elink_mem [MAX_EDGES];
   logic [NODE_W-1:0]      edst_rdata_ff;
   logic signed [WEIGHT_BITS-1:0] ewt_rdata_ff;
   logic [LINK_W-1:0]      elink_rdata_ff;
   logic signed [DIST_W-1:0] dist_mem [MAX_NODES];
   logic signed [DIST_W-1:0] dist_rdata_ff;
   logic [CNT_W-1:0]       cnt_mem [MAX_NODES];
   logic [CNT_W-1:0]       cnt_rdata_ff;
   logic [NODE_W-1:0]      wq_mem [MAX_NODES];
   logic [NODE_W-1:0]      wq_rdata_ff;

   logic req_acc, rsp_acc, store_full, edge_take;
   logic [LINK_W-1:0] st_link;
   logic head_re, edge_re, dist_re, cnt_re, wq_re;
   logic [NODE_W-1:0] head_ra, dist_ra, cnt_ra;
   logic [EIDX_W-1:0] edge_ra;
   logic dist_we, cnt_we, wq_we;
   logic [NODE_W-1:0] dist_wa, cnt_wa;
   logic signed [DIST_W-1:0] dist_wd;
   logic [CNT_W-1:0] cnt_wd, cnt_cur, cnt_new;
   logic [NODE_W-1:0] wq_wd;
   logic signed [DIST_W-1:0] cand;
   logic improve, v_in_range, do_update, do_push, src_ok, out_last, out_load;

   always_comb begin
      if (node_count_ff == '0) n_eff = CFG_W'(1);
      else if (node_count_ff > CFG_W'(MAX_NODES)) n_eff = CFG_W'(MAX_NODES);
      else n_eff = node_count_ff;
   end

   assign req_bus.ready = (state_ff == ST_LOAD);
   assign req_acc    = req_bus.valid && req_bus.ready;
   assign rsp_acc    = rsp_bus.valid && rsp_bus.ready;
   assign store_full = edges_loaded_ff[EIDX_W];
   assign edge_take  = req_acc && !store_full;

   always_comb begin
      if (fwd_vld_ff && fwd_from_ff == st_from_ff) st_link = {1'b0, fwd_e_ff};
      else if (head_vld_ff[st_from_ff]) st_link = {1'b0, head_rdata_ff};
      else st_link = LINK_NONE;
   end

   spfa_relax u_relax (
      .du(du_ff), .weight(ewt_rdata_ff), .dist_v(dist_rdata_ff),
      .reached_v(reached_ff[edst_rdata_ff]), .cand(cand), .improve(improve)
   );

   assign v_in_range = CFG_W'(edst_rdata_ff) < n_eff;
   assign do_update  = (state_ff == ST_RELAX) && v_in_range && improve;
   assign do_push    = do_update && !queued_ff[edst_rdata_ff];
   assign cnt_cur    = cnt_vld_ff[edst_rdata_ff] ? cnt_rdata_ff : '0;
   assign cnt_new    = cnt_cur + CNT_W'(1);
   assign src_ok     = CFG_W'(source_ff) < n_eff;
   assign out_last   = CFG_W'(k_ff) == n_eff - CFG_W'(1);
   assign out_load   = (state_ff == ST_OUT_LD) && (!rsp_bus.valid || rsp_bus.ready);

   always_comb begin
      head_re = 1'b0; head_ra = req_bus.edge_from;
      edge_re = 1'b0; edge_ra = head_rdata_ff;
      dist_re = 1'b0; dist_ra = wq_rdata_ff;
      cnt_re  = 1'b0; cnt_ra  = edst_rdata_ff;
      wq_re   = 1'b0;
      dist_we = 1'b0; dist_wa = source_ff; dist_wd = '0;
      cnt_we  = 1'b0; cnt_wa  = source_ff; cnt_wd  = CNT_W'(1);
      wq_we   = 1'b0; wq_wd   = source_ff;
      case (state_ff)
         ST_LOAD: begin
            head_re = edge_take;
         end
         ST_INIT: begin
            dist_we = src_ok;
            cnt_we  = src_ok;
            wq_we   = src_ok;
         end
         ST_POP: begin
            wq_re = (q_len_ff != '0);
         end
         ST_POP_W: begin
            head_re = 1'b1; head_ra = wq_rdata_ff;
            dist_re = 1'b1; dist_ra = wq_rdata_ff;
         end
         ST_HEAD_W: begin
            edge_re = head_vld_ff[u_ff];
         end
         ST_EDGE_W: begin
            dist_re = 1'b1; dist_ra = edst_rdata_ff;
            cnt_re  = 1'b1;
         end
         ST_RELAX: begin
            dist_we = do_update; dist_wa = edst_rdata_ff; dist_wd = cand;
            cnt_we  = do_push; cnt_wa = edst_rdata_ff; cnt_wd = cnt_new;
            wq_we   = do_push; wq_wd = edst_rdata_ff;
            edge_re = !elink_rdata_ff[EIDX_W];
            edge_ra = elink_rdata_ff[EIDX_W-1:0];
         end
         ST_OUT_RD: begin
            dist_re = 1'b1; dist_ra = k_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_vld_ff) head_mem[st_from_ff] <= st_e_ff;
      if (head_re) head_rdata_ff <= head_mem[head_ra];
   end

   always_ff @(posedge clock) begin
      if (edge_take) begin
         edst_mem[edges_loaded_ff[EIDX_W-1:0]] <= req_bus.edge_to;
         ewt_mem[edges_loaded_ff[EIDX_W-1:0]]  <= req_bus.edge_weight;
      end
      if (st_vld_ff) elink_mem[st_e_ff] <= st_link;
      if (edge_re) begin
         edst_rdata_ff  <= edst_mem[edge_ra];
         ewt_rdata_ff   <= ewt_mem[edge_ra];
         elink_rdata_ff <= elink_mem[edge_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (dist_we) dist_mem[dist_wa] <= dist_wd;
      if (dist_re) dist_rdata_ff <= dist_mem[dist_ra];
      if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
      if (cnt_re) cnt_rdata_ff <= cnt_mem[cnt_ra];
      if (wq_we) wq_mem[q_tail_ff] <= wq_wd;
      if (wq_re) wq_rdata_ff <= wq_mem[q_head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LOAD;
         node_count_ff   <= CFG_W'(MAX_NODES);
         source_ff       <= '0;
         edges_loaded_ff <= '0;
         overflow_ff     <= 1'b0;
         st_vld_ff       <= 1'b0;
         fwd_vld_ff      <= 1'b0;
         head_vld_ff     <= '0;
         reached_ff      <= '0;
         queued_ff       <= '0;
         cnt_vld_ff      <= '0;
         q_head_ff       <= '0;
         q_tail_ff       <= '0;
         q_len_ff        <= '0;
         neg_ff          <= 1'b0;
         k_ff            <= '0;
         rsp_bus.valid   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_NODE_COUNT:  node_count_ff <= csr_write_data;
               REG_SOURCE_NODE: source_ff <= csr_write_data[NODE_W-1:0];
               default: begin
               end
            endcase
         end

         st_vld_ff   <= edge_take;
         st_from_ff  <= req_bus.edge_from;
         st_e_ff     <= edges_loaded_ff[EIDX_W-1:0];
         fwd_vld_ff  <= st_vld_ff;
         fwd_from_ff <= st_from_ff;
         fwd_e_ff    <= st_e_ff;
         if (st_vld_ff) head_vld_ff[st_from_ff] <= 1'b1;
         if (edge_take) edges_loaded_ff <= edges_loaded_ff + (EIDX_W+1)'(1);
         if (req_acc && store_full) overflow_ff <= 1'b1;

         if (rsp_acc) rsp_bus.valid <= 1'b0;

         case (state_ff)
            ST_LOAD: begin
               if (req_acc && req_bus.last_edge) state_ff <= ST_DRAIN;
            end
            ST_DRAIN: begin
               state_ff <= ST_INIT;
            end
            ST_INIT: begin
               reached_ff <= '0;
               queued_ff  <= '0;
               cnt_vld_ff <= '0;
               // queue restarts at the slot the source word is written to
               q_head_ff  <= q_tail_ff;
               neg_ff     <= 1'b0;
               k_ff       <= '0;
               if (src_ok) begin
                  reached_ff[source_ff] <= 1'b1;
                  queued_ff[source_ff]  <= 1'b1;
                  cnt_vld_ff[source_ff] <= 1'b1;
                  q_tail_ff <= q_tail_ff + NODE_W'(1);
                  q_len_ff  <= CNT_W'(1);
                  state_ff  <= ST_POP;
               end else begin
                  q_len_ff  <= '0;
                  state_ff  <= ST_OUT_RD;
               end
            end
            ST_POP: begin
               if (q_len_ff == '0) begin
                  state_ff <= ST_OUT_RD;
               end else begin
                  q_head_ff <= q_head_ff + NODE_W'(1);
                  q_len_ff  <= q_len_ff - CNT_W'(1);
                  state_ff  <= ST_POP_W;
               end
            end
            ST_POP_W: begin
               u_ff <= wq_rdata_ff;
               queued_ff[wq_rdata_ff] <= 1'b0;
               state_ff <= ST_HEAD_W;
            end
            ST_HEAD_W: begin
               du_ff <= dist_rdata_ff;
               state_ff <= head_vld_ff[u_ff] ? ST_EDGE_W : ST_POP;
            end
            ST_EDGE_W: begin
               state_ff <= ST_RELAX;
            end
            ST_RELAX: begin
               if (do_update) begin
                  reached_ff[edst_rdata_ff] <= 1'b1;
                  if (edst_rdata_ff == u_ff) du_ff <= cand;
               end
               if (do_push) begin
                  queued_ff[edst_rdata_ff]  <= 1'b1;
                  cnt_vld_ff[edst_rdata_ff] <= 1'b1;
                  q_tail_ff <= q_tail_ff + NODE_W'(1);
                  q_len_ff  <= q_len_ff + CNT_W'(1);
               end
               if (do_push && CFG_W'(cnt_new) >= n_eff) begin
                  neg_ff   <= 1'b1;
                  state_ff <= ST_OUT_RD;
               end else if (elink_rdata_ff[EIDX_W]) begin
                  state_ff <= ST_POP;
               end else begin
                  state_ff <= ST_EDGE_W;
               end
            end
            ST_OUT_RD: begin
               state_ff <= ST_OUT_LD;
            end
            ST_OUT_LD: begin
               if (out_load) begin
                  rsp_bus.valid          <= 1'b1;
                  rsp_bus.node_index     <= k_ff;
                  rsp_bus.reachable      <= reached_ff[k_ff];
                  rsp_bus.distance       <= reached_ff[k_ff] ? dist_rdata_ff : INF_DIST;
                  rsp_bus.negative_cycle <= neg_ff;
                  rsp_bus.edge_overflow  <= overflow_ff;
                  rsp_bus.last_result    <= out_last;
                  if (out_last) begin
                     head_vld_ff     <= '0;
                     edges_loaded_ff <= '0;
                     overflow_ff     <= 1'b0;
                     state_ff        <= ST_LOAD;
                  end else begin
                     k_ff     <= k_ff + NODE_W'(1);
                     state_ff <= ST_OUT_RD;
                  end
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end
endmodule

// ----- rtl/core/spfa_checker.sv -----
// Port-level assertions for the SPFA block, bound to the top level.
module spfa_checker import spfa_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     req_last_edge,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [DIST_W-1:0] rsp_distance,
   input logic                     rsp_reachable,
   input logic                     rsp_last_result
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_no_load_in_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> !req_ready)
      else $error("edge input open during result output");

   a_stop_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_edge |=> !req_ready)
      else $error("edge input still open after last edge");

   a_unreached_inf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_reachable |-> rsp_distance == INF_DIST)
      else $error("unreached node with finite distance");
endmodule

bind spfa_shortest_path spfa_checker u_spfa_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_bus.valid),
   .req_ready(req_bus.ready),
   .req_last_edge(req_bus.last_edge),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .rsp_distance(rsp_bus.distance),
   .rsp_reachable(rsp_bus.reachable),
   .rsp_last_result(rsp_bus.last_result)
);
